>>> hw/rtl/hatp_pkg.sv
// ----------------------------------------------------------------------------
// hatp_pkg: shared constants for the heading / turn rate pid controller
// operation codes, register indexes and fixed point limits
// ----------------------------------------------------------------------------
package hatp_pkg;

    // operation codes carried in tuser
    localparam logic [1:0] OP_SET_GOAL = 2'd0;
    localparam logic [1:0] OP_STEP     = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_GAIN_P      = 3'd0;
    localparam logic [2:0] REG_GAIN_I      = 3'd1;
    localparam logic [2:0] REG_GAIN_D      = 3'd2;
    localparam logic [2:0] REG_STEP_PERIOD = 3'd3;
    localparam logic [2:0] REG_STEP_RATE   = 3'd4;
    localparam logic [2:0] REG_HOLD_MS     = 3'd5;

    localparam int MUL_W  = 64;  // product accumulator width
    localparam int MPL_W  = 24;  // multiplier width, one bit per cycle

    // pi and 2 pi in q.12
    localparam logic signed [17:0] PI_Q     = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q = 18'sd25736;

    // integral clear threshold, 10 in q.20
    localparam logic signed [27:0] INT_LIMIT = 28'sd10485760;

    localparam logic signed [39:0] TURN_MAX = 40'sd8388607;
    localparam logic signed [39:0] TURN_MIN = -40'sd8388608;

    // round half up, then drop eight fraction bits
    function automatic logic signed [MUL_W-1:0] round8(input logic signed [MUL_W-1:0] x);
        logic signed [MUL_W-1:0] t;
        begin
            t = x + 64'sd128;
            return t >>> 8;
        end
    endfunction

endpackage

>>> hw/rtl/hatp_mul.sv
// ----------------------------------------------------------------------------
// hatp_mul: bit-serial multiplier
// signed multiplicand times unsigned multiplier, one multiplier bit a cycle
// ----------------------------------------------------------------------------
module hatp_mul
    import hatp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [MUL_W-1:0] mcand,
    input  logic [MPL_W-1:0]        mplier,
    output logic                    done,
    output logic signed [MUL_W-1:0] prod
);

    logic signed [MUL_W-1:0] a_reg, a_next;
    logic signed [MUL_W-1:0] p_reg, p_next;
    logic [MPL_W-1:0]        b_reg, b_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = mcand;
            b_next    = mplier;
            p_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                p_next = p_reg + a_reg;
            a_next   = a_reg <<< 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(MPL_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

>>> hw/rtl/heading_and_turn_rate_pid_top.sv
// ----------------------------------------------------------------------------
// heading_and_turn_rate_pid_top: pid steering controller, turn rate or heading
// control step: five serial multiplies, each a load, one step per multiplier bit
//   and done; then saturate and output
//   a step inside the hold window goes straight to output
// throughput: one item at a time, next word taken only once the sequencer is back
//   in idle; set goal and clear words taken every cycle while idle
// reset: all controller state zero, gains and timing at default values
// ----------------------------------------------------------------------------
module heading_and_turn_rate_pid_top
    import hatp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // goal_rate, meas_rate, meas_heading, speed_in, now_ms
    input  logic [1:0]  s_axis_tuser,  // op
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // speed_out, turn_out
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_SAT  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    // configuration registers
    logic [23:0] gain_p_reg, gain_i_reg, gain_d_reg, step_rate_reg;
    logic [15:0] step_period_reg, hold_ms_reg;

    // controller state
    logic signed [15:0] goal_reg;
    logic               was_turning_reg;
    logic               hold_active_reg;
    logic [31:0]        hold_start_reg;
    logic signed [14:0] target_reg;
    logic signed [27:0] integ_reg;
    logic signed [15:0] prev_reg;

    // working registers of one step
    logic [2:0]         state_reg;
    logic [2:0]         ph_reg;
    logic signed [16:0] e_reg;
    logic signed [17:0] de_reg;
    logic signed [27:0] ei_reg;
    logic signed [33:0] ed_reg;
    logic signed [63:0] acc_reg;
    logic signed [23:0] turn_reg;
    logic signed [15:0] speed_reg;

    // output register
    logic        out_valid_reg;
    logic [39:0] out_data_reg;

    // input fields
    logic [1:0]         op;
    logic signed [15:0] goal_rate, meas_rate, speed_in;
    logic signed [14:0] meas_heading;
    logic [31:0]        now_ms;

    assign goal_rate    = s_axis_tdata[15:0];
    assign meas_rate    = s_axis_tdata[31:16];
    assign meas_heading = s_axis_tdata[46:32];
    assign speed_in     = s_axis_tdata[62:47];
    assign now_ms       = s_axis_tdata[94:63];
    assign op           = s_axis_tuser;

    logic in_acc;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // heading error, wrapped into (-pi, pi]
    logic signed [14:0] th_eff;
    logic signed [17:0] hdiff, wx, wr;
    logic signed [16:0] head_err;
    logic               in_hold;
    logic [31:0]        held_ms;

    assign th_eff  = hold_active_reg ? meas_heading : target_reg;
    assign hdiff   = 18'(th_eff) - 18'(meas_heading);
    assign wx      = PI_Q - hdiff;
    assign held_ms = now_ms - hold_start_reg;
    assign in_hold = hold_active_reg && (held_ms <= {16'd0, hold_ms_reg});

    always_comb
    begin
        if (wx < 0)
            wr = wx + TWO_PI_Q;
        else if (wx >= TWO_PI_Q)
            wr = wx - TWO_PI_Q;
        else
            wr = wx;
    end
    assign head_err = 17'(PI_Q - wr);

    // shared serial multiplier, operands chosen by phase
    logic               mul_start;
    logic signed [63:0] mul_a, mul_p, mul_r;
    logic [23:0]        mul_b;
    logic               mul_done;

    assign mul_start = (state_reg == ST_LOAD);
    assign mul_r     = round8(mul_p);

    always_comb
    begin
        case (ph_reg)
            3'd0:
            begin
                mul_a = 64'(e_reg);
                mul_b = {8'd0, step_period_reg};
            end
            3'd1:
            begin
                mul_a = 64'(de_reg);
                mul_b = step_rate_reg;
            end
            3'd2:
            begin
                mul_a = 64'(e_reg);
                mul_b = gain_p_reg;
            end
            3'd3:
            begin
                mul_a = 64'(ed_reg);
                mul_b = gain_d_reg;
            end
            default:
            begin
                mul_a = 64'(ei_reg);
                mul_b = gain_i_reg;
            end
        endcase
    end

    hatp_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_a),
        .mplier (mul_b),
        .done   (mul_done),
        .prod   (mul_p)
    );

    // final rounding, saturation compares the full width
    logic signed [63:0] w_full;
    assign w_full = (acc_reg + 64'sd32768) >>> 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg      <= 24'd524288;
            gain_i_reg      <= 24'd655;
            gain_d_reg      <= 24'd655;
            step_period_reg <= 16'd1311;
            step_rate_reg   <= 24'd12800;
            hold_ms_reg     <= 16'd120;
            goal_reg        <= '0;
            was_turning_reg <= 1'b0;
            hold_active_reg <= 1'b0;
            hold_start_reg  <= '0;
            target_reg      <= '0;
            integ_reg       <= '0;
            prev_reg        <= '0;
            state_reg       <= ST_IDLE;
            ph_reg          <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_GAIN_P:      gain_p_reg      <= cfg_data;
                    REG_GAIN_I:      gain_i_reg      <= cfg_data;
                    REG_GAIN_D:      gain_d_reg      <= cfg_data;
                    REG_STEP_PERIOD: step_period_reg <= cfg_data[15:0];
                    REG_STEP_RATE:   step_rate_reg   <= cfg_data;
                    REG_HOLD_MS:     hold_ms_reg     <= cfg_data[15:0];
                    default: ;
                endcase
            end

            // result word launched from the output state, dropped once taken
            if (state_reg == ST_OUT && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (op)
                            OP_SET_GOAL:
                            begin
                                if (goal_rate == 0 && was_turning_reg)
                                begin
                                    hold_active_reg <= 1'b1;
                                    hold_start_reg  <= now_ms;
                                end
                                was_turning_reg <= (goal_rate != 0);
                                goal_reg        <= goal_rate;
                                if (goal_rate == 0)
                                begin
                                    integ_reg <= '0;
                                    prev_reg  <= '0;
                                end
                            end
                            OP_CLEAR:
                            begin
                                integ_reg       <= '0;
                                prev_reg        <= '0;
                                target_reg      <= '0;
                                was_turning_reg <= 1'b0;
                            end
                            OP_STEP:
                            begin
                                ph_reg <= '0;
                                if (goal_reg != 0)
                                begin
                                    // turn rate tracking, previous error kept
                                    e_reg     <= 17'(goal_reg) - 17'(meas_rate);
                                    de_reg    <= 18'(goal_reg) - 18'(meas_rate)
                                                 - 18'(prev_reg);
                                    state_reg <= ST_LOAD;
                                end
                                else if (in_hold)
                                begin
                                    // zero turn inside the hold window
                                    integ_reg <= '0;
                                    turn_reg  <= '0;
                                    state_reg <= ST_OUT;
                                end
                                else
                                begin
                                    // heading hold, latch heading once after the window
                                    hold_active_reg <= 1'b0;
                                    target_reg      <= th_eff;
                                    e_reg           <= head_err;
                                    de_reg          <= 18'(head_err) - 18'(prev_reg);
                                    prev_reg        <= head_err[15:0];
                                    state_reg       <= ST_LOAD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_LOAD:
                    state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (mul_done)
                    begin
                        case (ph_reg)
                            3'd0: ei_reg  <= integ_reg + mul_r[27:0];
                            3'd1: ed_reg  <= mul_r[33:0];
                            3'd2: acc_reg <= mul_p;
                            3'd3: acc_reg <= acc_reg + mul_p;
                            default: acc_reg <= acc_reg + mul_r;
                        endcase
                        ph_reg    <= ph_reg + 3'd1;
                        state_reg <= (ph_reg == 3'd4) ? ST_SAT : ST_LOAD;
                    end
                end
                ST_SAT:
                begin
                    if (w_full > TURN_MAX)
                        turn_reg <= 24'sh7FFFFF;
                    else if (w_full < TURN_MIN)
                        turn_reg <= 24'sh800000;
                    else
                        turn_reg <= w_full[23:0];
                    // integral clears once its magnitude passes the limit
                    if (ei_reg > INT_LIMIT || ei_reg < -INT_LIMIT)
                        integ_reg <= '0;
                    else
                        integ_reg <= ei_reg;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload side of the step
    always_ff @(posedge clk)
    begin
        if (in_acc && op == OP_STEP)
            speed_reg <= speed_in;
        if (state_reg == ST_OUT && (!out_valid_reg || m_axis_tready))
            out_data_reg <= {turn_reg, speed_reg};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // checks
    a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ST_WAIT)
        else $error("multiplier finished outside wait state");

    a_other_ops_no_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && op != OP_STEP) |=> state_reg == ST_IDLE)
        else $error("non-step word started work");

    a_integ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        integ_reg <= INT_LIMIT && integ_reg >= -INT_LIMIT)
        else $error("integral beyond limit");

    a_out_after_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result word without output state");

endmodule
